// ===== src/wgtg_pkg.sv =====
// Shared constants, types and helpers for the waypoint go-to-goal controller.
package wgtg_pkg;

   localparam int DEF_MAX_WAYPOINTS     = 64;
   localparam int DEF_CORDIC_ITERATIONS = 24;

   // datapath widths
   localparam int XW      = 36;  // CORDIC x/y
   localparam int ZW      = 28;  // CORDIC angle, 2^-24 rad
   localparam int EW      = 29;  // heading error, 2^-24 rad
   localparam int E13W    = 16;  // heading error, 1/8192 rad
   localparam int MACCW   = 60;  // x * 1/K accumulator
   localparam int DISTW   = 36;
   localparam int LACCW   = 54;  // dist * linear gain
   localparam int AACCW   = 35;  // err * angular gain
   localparam int GAINW   = 18;
   localparam int TOLHW   = 15;
   localparam int TOLDW   = 31;
   localparam int GCW     = 7;
   localparam int GIW     = 7;
   localparam int LINW    = 31;
   localparam int ANGW    = 18;
   localparam int INVKW   = 24;
   localparam int DIGW    = 4;
   localparam int MAG_DIGITS  = INVKW / 2;
   localparam int GAIN_DIGITS = GAINW / 2;

   localparam logic [INVKW-1:0] INV_K_Q24 = 24'd10188014;
   localparam logic signed [EW-1:0] PI_Q24     = 29'sd52707179;
   localparam logic signed [EW-1:0] TWO_PI_Q24 = 29'sd105414357;

   // csr register indexes
   localparam logic [2:0] CSR_ANG_GAIN  = 3'd0;
   localparam logic [2:0] CSR_LIN_GAIN  = 3'd1;
   localparam logic [2:0] CSR_HEAD_TOL  = 3'd2;
   localparam logic [2:0] CSR_DIST_TOL  = 3'd3;
   localparam logic [2:0] CSR_GOAL_CNT  = 3'd4;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_POSE   = 2'd1,
      CMD_NOPOSE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_ORIENT  = 2'd0,
      PH_MOVE    = 2'd1,
      PH_ADVANCE = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_FETCH   = 12'b0000_0000_0010,
      ST_PREP    = 12'b0000_0000_0100,
      ST_FOLD    = 12'b0000_0000_1000,
      ST_CORDIC  = 12'b0000_0001_0000,
      ST_MAGMUL  = 12'b0000_0010_0000,
      ST_ERR     = 12'b0000_0100_0000,
      ST_WRAP    = 12'b0000_1000_0000,
      ST_GAINMUL = 12'b0001_0000_0000,
      ST_FINAL   = 12'b0010_0000_0000,
      ST_EMIT    = 12'b0100_0000_0000,
      ST_SPARE   = 12'b1000_0000_0000
   } state_type;

   // arctangent of 2^-i in 2^-24 rad
   function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0: r = 28'sd13176795;
         5'd1: r = 28'sd7778716;
         5'd2: r = 28'sd4110060;
         5'd3: r = 28'sd2086331;
         5'd4: r = 28'sd1047214;
         5'd5: r = 28'sd524117;
         5'd6: r = 28'sd262123;
         5'd7: r = 28'sd131069;
         default: begin
            if (i <= 5'd24) begin
               r = ZW'(28'sd1 <<< (5'd24 - i));
            end else begin
               r = '0;
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ===== src/waypoint_go_to_goal_controller.sv =====
// Waypoint go-to-goal controller: table, phase sequencer, serial CORDIC and multipliers.
// Pose update: fetch (when a waypoint is fetched first), prep, fold, CORDIC, 1/K multiply,
//   error, wrap (repeated when the heading error wraps), gain multiply, final, emit;
//   the CORDIC does one step a cycle and the multipliers 2 bits a cycle. Advancing update:
//   fetch; load: write; pose-unavailable: emit. One request at a time; a finished result waits
//   in the output register while the next request is taken, a stalled output holds the next.
// Reset: registers to their defaults, phase orienting, goal 0, not started; table undefined.
module waypoint_go_to_goal_controller #(
   parameter int MAX_WAYPOINTS     = wgtg_pkg::DEF_MAX_WAYPOINTS,
   parameter int CORDIC_ITERATIONS = wgtg_pkg::DEF_CORDIC_ITERATIONS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // waypoint_slot, waypoint_x, waypoint_y, pose_x, pose_y, pose_yaw, zero pad
   input  logic [151:0] req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // linear_speed, turn_rate, current_goal, zero pad
   output logic [55:0]  rsp_tdata,
   // phase_reached
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [30:0]  csr_data
);

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int IW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam int XW    = wgtg_pkg::XW;
   localparam int ZW    = wgtg_pkg::ZW;
   localparam int EW    = wgtg_pkg::EW;
   localparam int E13W  = wgtg_pkg::E13W;
   localparam int MACCW = wgtg_pkg::MACCW;
   localparam int DISTW = wgtg_pkg::DISTW;
   localparam int LACCW = wgtg_pkg::LACCW;
   localparam int AACCW = wgtg_pkg::AACCW;
   localparam int GAINW = wgtg_pkg::GAINW;
   localparam int INVKW = wgtg_pkg::INVKW;
   localparam int DIGW  = wgtg_pkg::DIGW;
   localparam int GIW   = wgtg_pkg::GIW;

   // request fields
   logic [5:0]         in_slot;
   logic signed [31:0] in_wx, in_wy, in_px, in_py;
   logic signed [15:0] in_yaw;
   wgtg_pkg::cmd_type  in_cmd;

   assign in_slot = req_tdata[5:0];
   assign in_wx   = req_tdata[37:6];
   assign in_wy   = req_tdata[69:38];
   assign in_px   = req_tdata[101:70];
   assign in_py   = req_tdata[133:102];
   assign in_yaw  = req_tdata[149:134];
   assign in_cmd  = wgtg_pkg::cmd_type'(req_tuser);

   // configuration
   logic [GAINW-1:0]           ang_gain_ff, lin_gain_ff;
   logic [wgtg_pkg::TOLHW-1:0] head_tol_ff;
   logic [wgtg_pkg::TOLDW-1:0] dist_tol_ff;
   logic [wgtg_pkg::GCW-1:0]   goal_cnt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_gain_ff <= 18'd32768;
         lin_gain_ff <= 18'd22938;
         head_tol_ff <= 15'd82;
         dist_tol_ff <= 31'd6554;
         goal_cnt_ff <= 7'd0;
      end else if (csr_valid) begin
         case (csr_index)
            wgtg_pkg::CSR_ANG_GAIN: ang_gain_ff <= csr_data[GAINW-1:0];
            wgtg_pkg::CSR_LIN_GAIN: lin_gain_ff <= csr_data[GAINW-1:0];
            wgtg_pkg::CSR_HEAD_TOL: head_tol_ff <= csr_data[wgtg_pkg::TOLHW-1:0];
            wgtg_pkg::CSR_DIST_TOL: dist_tol_ff <= csr_data;
            wgtg_pkg::CSR_GOAL_CNT: goal_cnt_ff <= csr_data[wgtg_pkg::GCW-1:0];
            default: ;
         endcase
      end
   end

   logic [wgtg_pkg::GCW-1:0] count;
   assign count = (32'(goal_cnt_ff) > MAX_WAYPOINTS) ? wgtg_pkg::GCW'(MAX_WAYPOINTS)
                                                     : goal_cnt_ff;

   // control and datapath registers
   wgtg_pkg::state_type state_ff;
   wgtg_pkg::phase_type phase_ff;
   logic [GIW-1:0]      goal_ff;
   logic                started_ff;
   logic                run_after_ff;
   logic [IW-1:0]       iter_ff;
   logic [DIGW-1:0]     dig_ff;

   logic signed [31:0]       tgt_x_ff, tgt_y_ff, pose_x_ff, pose_y_ff;
   logic signed [15:0]       yaw_ff;
   logic signed [XW-1:0]     cx_ff, cy_ff;
   logic signed [ZW-1:0]     z_ff;
   logic [INVKW-1:0]         kreg_ff;
   logic [MACCW-1:0]         macc_ff;
   logic [DISTW-1:0]         dist_ff;
   logic signed [EW-1:0]     err_ff;
   logic signed [E13W-1:0]   e13_ff;
   logic [GAINW-1:0]         ga_ff, gl_ff;
   logic signed [AACCW-1:0]  aacc_ff;
   logic [LACCW-1:0]         lacc_ff;
   logic [wgtg_pkg::LINW-1:0]       res_lin_ff, rsp_lin_ff;
   logic signed [wgtg_pkg::ANGW-1:0] res_ang_ff, rsp_ang_ff;
   logic                     res_reached_ff, rsp_reached_ff;
   logic [5:0]               rsp_goal_ff;
   logic                     rsp_valid_ff;

   logic [63:0] wp_mem [MAX_WAYPOINTS];

   assign req_tready = (state_ff == wgtg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_goal_ff, rsp_ang_ff, rsp_lin_ff};
   assign rsp_tuser  = rsp_reached_ff;

   logic accept, slot_ok, out_free;
   assign accept   = req_tvalid && req_tready;
   assign slot_ok  = 32'(in_slot) < MAX_WAYPOINTS;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (accept && in_cmd == wgtg_pkg::CMD_LOAD && slot_ok) begin
         wp_mem[AW'(in_slot)] <= {in_wy, in_wx};
      end
   end

   // CORDIC step
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] atn;
   logic                 y_pos;
   assign xs    = cx_ff >>> iter_ff;
   assign ys    = cy_ff >>> iter_ff;
   assign atn   = wgtg_pkg::atan_step(5'(iter_ff));
   assign y_pos = !cy_ff[XW-1] && (cy_ff != '0);

   // magnitude scaling digit
   logic [MACCW-1:0] xm, mpp;
   assign xm  = cx_ff[XW-1] ? '0 : MACCW'(cx_ff);
   assign mpp = (kreg_ff[INVKW-1] ? (xm << 1) : '0) + (kreg_ff[INVKW-2] ? xm : '0);

   // gain digits
   logic signed [AACCW-1:0] e_ext, app;
   logic [LACCW-1:0]        d_ext, lpp;
   assign e_ext = AACCW'(e13_ff);
   assign app   = (ga_ff[GAINW-1] ? (e_ext <<< 1) : '0) + (ga_ff[GAINW-2] ? e_ext : '0);
   assign d_ext = LACCW'(dist_ff);
   assign lpp   = (gl_ff[GAINW-1] ? (d_ext << 1) : '0) + (gl_ff[GAINW-2] ? d_ext : '0);

   // heading error: yaw alignment and rounding
   logic signed [EW-1:0] yaw_q24, err_rnd;
   assign yaw_q24 = {{(EW-27){yaw_ff[15]}}, yaw_ff, 11'b0};
   assign err_rnd = err_ff + EW'(1024);

   // final scaling, saturation and tolerance checks
   logic signed [AACCW-1:0] aacc_rnd;
   logic signed [AACCW-17:0] ang_full;
   logic [LACCW-1:0]        lacc_rnd;
   logic [LACCW-17:0]       lin_full;
   logic signed [wgtg_pkg::ANGW-1:0] ang_sat;
   logic [wgtg_pkg::LINW-1:0]        lin_sat;
   logic [E13W:0]           e13_abs;
   logic                    head_ok, dist_ok;

   assign aacc_rnd = aacc_ff + AACCW'(32768);
   assign ang_full = aacc_rnd[AACCW-1:16];
   assign lacc_rnd = lacc_ff + LACCW'(32768);
   assign lin_full = lacc_rnd[LACCW-1:16];
   assign ang_sat  = (ang_full > (AACCW-16)'(131071))  ? 18'sd131071 :
                     (ang_full < -(AACCW-16)'(131072)) ? -18'sd131072 :
                     ang_full[wgtg_pkg::ANGW-1:0];
   assign lin_sat  = (lin_full[LACCW-17:wgtg_pkg::LINW] != '0) ? '1
                                                              : lin_full[wgtg_pkg::LINW-1:0];
   assign e13_abs  = e13_ff[E13W-1] ? (E13W+1)'(-e13_ff) : (E13W+1)'(e13_ff);
   assign head_ok  = e13_abs <= (E13W+1)'(head_tol_ff);
   assign dist_ok  = dist_ff <= DISTW'(dist_tol_ff);

   logic [GIW-1:0] goal_next;
   assign goal_next = goal_ff + GIW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wgtg_pkg::ST_IDLE;
         phase_ff     <= wgtg_pkg::PH_ORIENT;
         goal_ff      <= '0;
         started_ff   <= 1'b0;
         run_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         dig_ff       <= '0;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != wgtg_pkg::ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            wgtg_pkg::ST_IDLE: begin
               if (accept) begin
                  pose_x_ff <= in_px;
                  pose_y_ff <= in_py;
                  yaw_ff    <= in_yaw;
                  case (in_cmd)
                     wgtg_pkg::CMD_NOPOSE: begin
                        res_lin_ff     <= '0;
                        res_ang_ff     <= '0;
                        res_reached_ff <= 1'b0;
                        state_ff       <= wgtg_pkg::ST_EMIT;
                     end
                     wgtg_pkg::CMD_POSE: begin
                        if (!started_ff) begin
                           if (count != '0) begin
                              goal_ff      <= '0;
                              phase_ff     <= wgtg_pkg::PH_ORIENT;
                              started_ff   <= 1'b1;
                              run_after_ff <= 1'b1;
                              state_ff     <= wgtg_pkg::ST_FETCH;
                           end
                        end else begin
                           case (phase_ff)
                              wgtg_pkg::PH_ADVANCE: begin
                                 goal_ff <= goal_next;
                                 if (goal_next < count) begin
                                    phase_ff     <= wgtg_pkg::PH_ORIENT;
                                    run_after_ff <= 1'b0;
                                    state_ff     <= wgtg_pkg::ST_FETCH;
                                 end else begin
                                    phase_ff <= wgtg_pkg::PH_DONE;
                                 end
                              end
                              wgtg_pkg::PH_DONE: ;
                              default: state_ff <= wgtg_pkg::ST_PREP;
                           endcase
                        end
                     end
                     default: ;
                  endcase
               end
            end
            wgtg_pkg::ST_FETCH: begin
               {tgt_y_ff, tgt_x_ff} <= wp_mem[AW'(goal_ff)];
               state_ff <= run_after_ff ? wgtg_pkg::ST_PREP : wgtg_pkg::ST_IDLE;
            end
            wgtg_pkg::ST_PREP: begin
               cx_ff    <= XW'(tgt_x_ff) - XW'(pose_x_ff);
               cy_ff    <= XW'(tgt_y_ff) - XW'(pose_y_ff);
               state_ff <= wgtg_pkg::ST_FOLD;
            end
            wgtg_pkg::ST_FOLD: begin
               // fold the left half-plane into the right one
               if (cx_ff[XW-1]) begin
                  cx_ff <= -cx_ff;
                  cy_ff <= -cy_ff;
                  z_ff  <= cy_ff[XW-1] ? -ZW'(wgtg_pkg::PI_Q24) : ZW'(wgtg_pkg::PI_Q24);
               end else begin
                  z_ff <= '0;
               end
               iter_ff  <= '0;
               state_ff <= wgtg_pkg::ST_CORDIC;
            end
            wgtg_pkg::ST_CORDIC: begin
               if (y_pos) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  z_ff  <= z_ff + atn;
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  z_ff  <= z_ff - atn;
               end
               iter_ff <= iter_ff + IW'(1);
               if (iter_ff == IW'(CORDIC_ITERATIONS - 1)) begin
                  kreg_ff  <= wgtg_pkg::INV_K_Q24;
                  macc_ff  <= '0;
                  dig_ff   <= '0;
                  state_ff <= wgtg_pkg::ST_MAGMUL;
               end
            end
            wgtg_pkg::ST_MAGMUL: begin
               macc_ff <= (macc_ff << 2) + mpp;
               kreg_ff <= kreg_ff << 2;
               dig_ff  <= dig_ff + DIGW'(1);
               if (dig_ff == DIGW'(wgtg_pkg::MAG_DIGITS - 1)) begin
                  state_ff <= wgtg_pkg::ST_ERR;
               end
            end
            wgtg_pkg::ST_ERR: begin
               dist_ff  <= DISTW'((macc_ff + MACCW'(1 << 23)) >> 24);
               err_ff   <= EW'(z_ff) - yaw_q24;
               state_ff <= wgtg_pkg::ST_WRAP;
            end
            wgtg_pkg::ST_WRAP: begin
               if (err_ff > wgtg_pkg::PI_Q24) begin
                  err_ff <= err_ff - wgtg_pkg::TWO_PI_Q24;
               end else if (err_ff <= -wgtg_pkg::PI_Q24) begin
                  err_ff <= err_ff + wgtg_pkg::TWO_PI_Q24;
               end else begin
                  e13_ff   <= E13W'(err_rnd >>> 11);
                  ga_ff    <= ang_gain_ff;
                  gl_ff    <= lin_gain_ff;
                  aacc_ff  <= '0;
                  lacc_ff  <= '0;
                  dig_ff   <= '0;
                  state_ff <= wgtg_pkg::ST_GAINMUL;
               end
            end
            wgtg_pkg::ST_GAINMUL: begin
               aacc_ff <= (aacc_ff <<< 2) + app;
               lacc_ff <= (lacc_ff << 2) + lpp;
               ga_ff   <= ga_ff << 2;
               gl_ff   <= gl_ff << 2;
               dig_ff  <= dig_ff + DIGW'(1);
               if (dig_ff == DIGW'(wgtg_pkg::GAIN_DIGITS - 1)) begin
                  state_ff <= wgtg_pkg::ST_FINAL;
               end
            end
            wgtg_pkg::ST_FINAL: begin
               if (phase_ff == wgtg_pkg::PH_ORIENT) begin
                  res_lin_ff <= '0;
                  if (head_ok) begin
                     phase_ff       <= wgtg_pkg::PH_MOVE;
                     res_ang_ff     <= '0;
                     res_reached_ff <= 1'b1;
                  end else begin
                     res_ang_ff     <= ang_sat;
                     res_reached_ff <= 1'b0;
                  end
               end else begin
                  if (dist_ok) begin
                     phase_ff       <= wgtg_pkg::PH_ADVANCE;
                     res_lin_ff     <= '0;
                     res_ang_ff     <= '0;
                     res_reached_ff <= 1'b1;
                  end else begin
                     res_lin_ff     <= lin_sat;
                     res_ang_ff     <= ang_sat;
                     res_reached_ff <= 1'b0;
                  end
               end
               state_ff <= wgtg_pkg::ST_EMIT;
            end
            wgtg_pkg::ST_EMIT: begin
               // hold until the output register frees up
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_lin_ff     <= res_lin_ff;
                  rsp_ang_ff     <= res_ang_ff;
                  rsp_reached_ff <= res_reached_ff;
                  rsp_goal_ff    <= goal_ff[5:0];
                  state_ff       <= wgtg_pkg::ST_IDLE;
               end
            end
            default: state_ff <= wgtg_pkg::ST_IDLE;
         endcase
      end
   end

   a_done_started: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wgtg_pkg::PH_DONE |-> started_ff)
      else $error("done phase without a started run");

   a_goal_in_table: assert property (@(posedge clock) disable iff (reset)
      (started_ff && phase_ff != wgtg_pkg::PH_DONE) |-> 32'(goal_ff) < MAX_WAYPOINTS)
      else $error("active goal index beyond the table");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wgtg_pkg::ST_EMIT))
      else $error("response raised outside the emit step");

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == wgtg_pkg::ST_CORDIC |-> 32'(iter_ff) < CORDIC_ITERATIONS)
      else $error("CORDIC step count overran");

endmodule

// ===== sim/tb_waypoint_go_to_goal_controller.sv =====
// Self-checking testbench for the waypoint go-to-goal controller.
module tb_waypoint_go_to_goal_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int         TABLE_SIZE  = 64;
   localparam longint     PI_FIX      = 52707179;
   localparam longint     TWO_PI_FIX  = 105414357;
   localparam longint     INV_GAIN    = 10188014;
   localparam longint     YAW_LIMIT   = 25736;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         DRAIN_WAIT  = 80;

   typedef struct {
      logic [30:0] lin;
      logic [17:0] ang;
      logic        reached;
      logic [5:0]  goal;
   } drive_cmd_type;

   class go_to_goal_scoreboard;
      longint wp_x[TABLE_SIZE];
      longint wp_y[TABLE_SIZE];
      wgtg_pkg::phase_type phase = wgtg_pkg::PH_ORIENT;
      int unsigned goal_idx = 0;
      longint tgt_x = 0, tgt_y = 0;
      bit started = 0;
      longint ang_gain = 32768, lin_gain = 22938;
      longint head_tol = 82, dist_tol = 6554, goal_cnt = 0;
      drive_cmd_type expected_cmds[$];
      int errors = 0;

      function void vectoring(longint x, longint y, output longint z, output longint mag);
         longint xs, ys;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? PI_FIX : -PI_FIX;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < wgtg_pkg::DEF_CORDIC_ITERATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += longint'(wgtg_pkg::atan_step(5'(i)));
            end else begin
               x -= ys; y += xs; z -= longint'(wgtg_pkg::atan_step(5'(i)));
            end
         end
         if (x < 0) x = 0;
         mag = (x * INV_GAIN + (64'sd1 <<< 23)) >>> 24;
      endfunction

      function void write_reg(logic [2:0] idx, logic [30:0] val);
         case (idx)
            wgtg_pkg::CSR_ANG_GAIN: ang_gain = val[17:0];
            wgtg_pkg::CSR_LIN_GAIN: lin_gain = val[17:0];
            wgtg_pkg::CSR_HEAD_TOL: head_tol = val[14:0];
            wgtg_pkg::CSR_DIST_TOL: dist_tol = val[30:0];
            wgtg_pkg::CSR_GOAL_CNT: goal_cnt = val[6:0];
            default: ;
         endcase
      endfunction

      function void push(longint lin, longint ang, bit reached);
         drive_cmd_type c;
         c.lin = lin[30:0];
         c.ang = ang[17:0];
         c.reached = reached;
         c.goal = goal_idx[5:0];
         expected_cmds.push_back(c);
      endfunction

      function void note_request(logic [1:0] cmd, logic [5:0] slot,
                                 logic signed [31:0] wx, logic signed [31:0] wy,
                                 logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [15:0] yaw);
         longint count, z, range_est, err, err13, ang, lin, mag;
         if (cmd == wgtg_pkg::CMD_LOAD) begin
            wp_x[slot] = wx;
            wp_y[slot] = wy;
            return;
         end
         if (cmd == wgtg_pkg::CMD_NOPOSE) begin
            push(0, 0, 0);
            return;
         end
         if (cmd == CMD_UNKNOWN) return;
         count = (goal_cnt > TABLE_SIZE) ? TABLE_SIZE : goal_cnt;
         if (!started) begin
            if (count == 0) return;
            goal_idx = 0;
            tgt_x = wp_x[0];
            tgt_y = wp_y[0];
            phase = wgtg_pkg::PH_ORIENT;
            started = 1;
         end
         if (phase == wgtg_pkg::PH_DONE) return;
         if (phase == wgtg_pkg::PH_ADVANCE) begin
            goal_idx = (goal_idx + 1) & 7'h7f;
            if (goal_idx < count) begin
               tgt_x = wp_x[goal_idx];
               tgt_y = wp_y[goal_idx];
               phase = wgtg_pkg::PH_ORIENT;
            end else begin
               phase = wgtg_pkg::PH_DONE;
            end
            return;
         end
         vectoring(tgt_x - longint'(px), tgt_y - longint'(py), z, range_est);
         err = z - longint'(yaw) * 2048;
         while (err > PI_FIX) err -= TWO_PI_FIX;
         while (err <= -PI_FIX) err += TWO_PI_FIX;
         err13 = (err + 1024) >>> 11;
         ang = (err13 * ang_gain + 32768) >>> 16;
         if (ang > 131071) ang = 131071;
         if (ang < -131072) ang = -131072;
         if (phase == wgtg_pkg::PH_ORIENT) begin
            mag = (err13 < 0) ? -err13 : err13;
            if (mag <= head_tol) begin
               phase = wgtg_pkg::PH_MOVE;
               push(0, 0, 1);
            end else begin
               push(0, ang, 0);
            end
            return;
         end
         if (range_est <= dist_tol) begin
            phase = wgtg_pkg::PH_ADVANCE;
            push(0, 0, 1);
            return;
         end
         lin = (range_est * lin_gain + 32768) >>> 16;
         if (lin > 64'sd2147483647) lin = 64'sd2147483647;
         push(lin, ang, 0);
      endfunction

      function void check_result(logic [30:0] lin, logic [17:0] ang, logic reached,
                                 logic [5:0] goal);
         drive_cmd_type e;
         if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected result lin=%0d ang=%0d reached=%0d goal=%0d",
                     $realtime, lin, ang, reached, goal);
            errors++;
            return;
         end
         e = expected_cmds.pop_front();
         if (lin !== e.lin) begin
            $display("%0t: linear_speed expected %0d actual %0d", $realtime, e.lin, lin);
            errors++;
         end
         if (ang !== e.ang) begin
            $display("%0t: turn_rate expected %0d actual %0d", $realtime,
                     $signed(e.ang), $signed(ang));
            errors++;
         end
         if (reached !== e.reached) begin
            $display("%0t: phase_reached expected %0d actual %0d", $realtime,
                     e.reached, reached);
            errors++;
         end
         if (goal !== e.goal) begin
            $display("%0t: current_goal expected %0d actual %0d", $realtime, e.goal, goal);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;  // slot, wp_x, wp_y, pose_x, pose_y, yaw, pad
   logic [1:0]   req_tuser = wgtg_pkg::CMD_LOAD;  // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;  // linear_speed, turn_rate, current_goal, pad
   logic         rsp_tuser;  // phase_reached
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [30:0]  csr_data = '0;

   go_to_goal_scoreboard sb = new();
   bit quiet = 0;
   int cycles = 0;
   int stall_left = 0;

   waypoint_go_to_goal_controller u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("waypoint_go_to_goal_controller regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[30:0], rsp_tdata[48:31], rsp_tuser, rsp_tdata[54:49]);
   end

   task automatic send_request(logic [1:0] cmd, logic [5:0] slot,
                               logic [31:0] wx, logic [31:0] wy,
                               logic [31:0] px, logic [31:0] py, logic [15:0] yaw);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, yaw, py, px, wy, wx, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, slot, wx, wy, px, py, yaw);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [30:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic longint rand_offset();
      longint v;
      case ($urandom_range(0, 2))
         0: v = $urandom_range(0, 2000);
         1: v = $urandom_range(0, 400000);
         default: v = longint'($urandom) >> $urandom_range(0, 31);
      endcase
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // Pick a pose that is likely to move the current goal to its next phase.
   task automatic random_pose(output logic [31:0] px, output logic [31:0] py,
                              output logic [15:0] yaw);
      longint z, range_est, q, span, y13;
      if ($urandom_range(0, 9) == 0) begin
         px = $urandom;
         py = $urandom;
      end else if (sb.phase == wgtg_pkg::PH_MOVE && $urandom_range(0, 1) == 0) begin
         span = sb.dist_tol / 4;
         q = (span > 0) ? longint'($urandom_range(0, 32'(span))) : 0;
         px = 32'(sb.tgt_x - q);
         q = (span > 0) ? longint'($urandom_range(0, 32'(span))) : 0;
         py = 32'(sb.tgt_y + q);
      end else begin
         px = 32'(sb.tgt_x - rand_offset());
         py = 32'(sb.tgt_y - rand_offset());
      end
      y13 = longint'($urandom_range(0, 32'(2 * YAW_LIMIT))) - YAW_LIMIT;
      if ($urandom_range(0, 2) != 0) begin
         sb.vectoring(sb.tgt_x - longint'($signed(px)), sb.tgt_y - longint'($signed(py)),
                      z, range_est);
         y13 = ((z + 1024) >>> 11) + longint'($urandom_range(0, 6)) - 3;
      end
      if (y13 > YAW_LIMIT) y13 = YAW_LIMIT;
      if (y13 < -YAW_LIMIT) y13 = -YAW_LIMIT;
      yaw = y13[15:0];
   endtask

   task automatic random_phase(int count);
      logic [31:0] px, py;
      logic [15:0] yaw;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         random_pose(px, py, yaw);
         if (pick < 8)
            send_request(wgtg_pkg::CMD_LOAD, 6'($urandom_range(0, 63)), $urandom, $urandom,
                         px, py, yaw);
         else if (pick < 15)
            send_request(wgtg_pkg::CMD_NOPOSE, 6'($urandom), $urandom, $urandom, px, py, yaw);
         else if (pick < 18)
            send_request(CMD_UNKNOWN, 6'($urandom), $urandom, $urandom, px, py, yaw);
         else
            send_request(wgtg_pkg::CMD_POSE, 6'($urandom), $urandom, $urandom, px, py, yaw);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table so no pose update ever reads an empty slot
      send_request(wgtg_pkg::CMD_LOAD, 6'd0, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0);
      send_request(wgtg_pkg::CMD_LOAD, 6'd1, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
      send_request(wgtg_pkg::CMD_LOAD, 6'd2, 32'h0, 32'h0, '0, '0, '0);
      for (int s = 3; s < TABLE_SIZE; s++)
         send_request(wgtg_pkg::CMD_LOAD, 6'(s), 32'(rand_offset()), 32'(rand_offset()),
                      '0, '0, '0);

      // no goals in use: pose gives nothing, unavailable pose still answers
      send_request(wgtg_pkg::CMD_POSE, 6'h3f, '1, '1, 32'h1234_5678, 32'hedcb_a987,
                   16'sd100);
      send_request(wgtg_pkg::CMD_NOPOSE, '0, '0, '0, '0, '0, '0);
      send_request(CMD_UNKNOWN, '1, '1, '1, '1, '1, '1);
      drain();

      write_csr(wgtg_pkg::CSR_GOAL_CNT, 31'd127);
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd0);
      // extremes of pose and yaw against the extreme first waypoint
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff, 16'sd25736);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, -16'sd25736);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 16'sd0);
      send_request(wgtg_pkg::CMD_NOPOSE, '0, '0, '0, '0, '0, '0);
      drain();

      write_csr(wgtg_pkg::CSR_ANG_GAIN, 31'd262143);
      write_csr(wgtg_pkg::CSR_LIN_GAIN, 31'd262143);
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd25736);
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'd0);
      // orienting passes at once; pose on the goal gives zero distance
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, '0, '0, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h0, 32'h0, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, '0, '0, 16'sd0);
      send_request(wgtg_pkg::CMD_POSE, '0, '0, '0, '0, '0, 16'sd0);
      drain();

      write_csr(wgtg_pkg::CSR_ANG_GAIN, 31'd32768);
      write_csr(wgtg_pkg::CSR_LIN_GAIN, 31'd22938);
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd82);
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'd6554);
      random_phase(110);
      drain();

      write_csr(wgtg_pkg::CSR_ANG_GAIN, 31'd0);
      write_csr(wgtg_pkg::CSR_LIN_GAIN, 31'd0);
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd400);
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'd2147483647);
      random_phase(80);
      drain();

      write_csr(wgtg_pkg::CSR_ANG_GAIN, 31'd262143);
      write_csr(wgtg_pkg::CSR_LIN_GAIN, 31'd262143);
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd25736);
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'd100000);
      write_csr(wgtg_pkg::CSR_GOAL_CNT, 31'd64);
      random_phase(110);
      drain();

      write_csr(wgtg_pkg::CSR_ANG_GAIN, 31'($urandom_range(0, 262143)));
      write_csr(wgtg_pkg::CSR_LIN_GAIN, 31'($urandom_range(0, 262143)));
      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'($urandom_range(0, 2000)));
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'($urandom_range(0, 1000000)));
      write_csr(wgtg_pkg::CSR_GOAL_CNT, 31'd40);
      random_phase(110);
      drain();

      write_csr(wgtg_pkg::CSR_HEAD_TOL, 31'd1000);
      write_csr(wgtg_pkg::CSR_DIST_TOL, 31'd50000);
      random_phase(100);
      drain();

      // shrink the goal list so the run finishes in done
      quiet = 1;
      write_csr(wgtg_pkg::CSR_GOAL_CNT, 31'd0);
      random_phase(90);
      drain();

      if (sb.errors == 0) begin
         $display("waypoint_go_to_goal_controller regression: pass");
      end else begin
         $display("waypoint_go_to_goal_controller regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/wgtg_pkg.sv
src/waypoint_go_to_goal_controller.sv
sim/tb_waypoint_go_to_goal_controller.sv
